/* rtl/core/mafcc_pkg.sv */
`timescale 1ns / 1ps

package mafcc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int NUM_W      = 26;   // coef * 1000 * kbps stays below 2**26
    localparam int KBPSK_W    = 19;   // 1000 * 448 fits in 19 bits
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int FLEN_W     = 12;
    localparam int HZ_W       = 16;

    localparam logic [7:0]  SYNC_B0      = 8'hFF;
    localparam logic [7:0]  SYNC_B1_MASK = 8'hE0;
    localparam logic [7:0]  MIN_FRAMES_RST = 8'd8;
    localparam logic [9:0]  KBPS_SCALE   = 10'd1000;
    localparam logic [7:0]  COEF_L1      = 8'd12;    // 384 / 32
    localparam logic [7:0]  COEF_1152    = 8'd144;   // 1152 / 8
    localparam logic [7:0]  COEF_576     = 8'd72;    // 576 / 8

    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] VER_MPEG2    = 2'd2;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] LAY_1        = 2'd3;
    localparam logic [1:0] LAY_2        = 2'd2;
    localparam logic [1:0] LAY_RESERVED = 2'd0;
    localparam logic [3:0] BRI_FREE     = 4'd0;
    localparam logic [3:0] BRI_BAD      = 4'hF;
    localparam logic [1:0] SRI_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        STOP_OK      = 3'd0,
        STOP_SYNC    = 3'd1,
        STOP_VERLAY  = 3'd2,
        STOP_BITRATE = 3'd3,
        STOP_RATE    = 3'd4,
        STOP_OVERRUN = 3'd5,
        STOP_CHANGED = 3'd6,
        STOP_ENDED   = 3'd7
    } stop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic mul;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic pre_ok;
        logic div_last;
        logic out_free;
    } stat_t;

    // kbit/s by bitrate index and column (L1, L2, L3 for MPEG1; L1, L2/L3 for MPEG2/2.5)
    localparam logic [8:0] KBPS_TAB [15][5] = '{
        '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd32,  9'd32,  9'd32,  9'd32,  9'd8},
        '{9'd64,  9'd48,  9'd40,  9'd48,  9'd16},
        '{9'd96,  9'd56,  9'd48,  9'd56,  9'd24},
        '{9'd128, 9'd64,  9'd56,  9'd64,  9'd32},
        '{9'd160, 9'd80,  9'd64,  9'd80,  9'd40},
        '{9'd192, 9'd96,  9'd80,  9'd96,  9'd48},
        '{9'd224, 9'd112, 9'd96,  9'd112, 9'd56},
        '{9'd256, 9'd128, 9'd112, 9'd128, 9'd64},
        '{9'd288, 9'd160, 9'd128, 9'd144, 9'd80},
        '{9'd320, 9'd192, 9'd160, 9'd160, 9'd96},
        '{9'd352, 9'd224, 9'd192, 9'd176, 9'd112},
        '{9'd384, 9'd256, 9'd224, 9'd192, 9'd128},
        '{9'd416, 9'd320, 9'd256, 9'd224, 9'd144},
        '{9'd448, 9'd384, 9'd320, 9'd256, 9'd160}
    };

    localparam logic [15:0] HZ_TAB [3][3] = '{
        '{16'd44100, 16'd22050, 16'd11025},
        '{16'd48000, 16'd24000, 16'd12000},
        '{16'd32000, 16'd16000, 16'd8000}
    };

endpackage

/* rtl/core/mafcc_ctrl.sv */
`timescale 1ns / 1ps

module mafcc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mafcc_pkg::stat_t stat,
    output mafcc_pkg::cmd_t  cmd
);
    import mafcc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                // decode result is registered this cycle; use the comb flag
                state_next = stat.pre_ok ? ST_MUL : ST_COMMIT;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/mafcc_datapath.sv */
`timescale 1ns / 1ps

module mafcc_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  mafcc_pkg::cmd_t  cmd,
    output mafcc_pkg::stat_t stat,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             mode,
    input  logic [31:0]      header_word,
    input  logic [30:0]      bytes_left,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             accepted,
    output logic [2:0]       stop_reason,
    output logic [11:0]      frame_length,
    output logic [15:0]      frame_count,
    output logic [31:0]      run_length,
    output logic             enough_frames,
    output logic [1:0]       version_code,
    output logic [1:0]       layer_code,
    output logic [15:0]      sample_rate_hz,
    output logic [1:0]       channel_mode
);
    import mafcc_pkg::*;

    // item registers
    logic                  mode_reg;
    logic [31:0]           hdr_reg;
    logic [30:0]           left_reg;
    stop_t                 pre_reason_reg;
    stop_t                 pre_reason_next;
    logic [KBPSK_W-1:0]    kbpsk_reg;
    logic [7:0]            coef_reg;
    logic [HZ_W-1:0]       hz_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [HZ_W-1:0]       rem_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // run state
    logic                  run_active_reg;
    logic [1:0]            first_ver_reg;
    logic [1:0]            first_lay_reg;
    logic [HZ_W-1:0]       first_rate_reg;
    logic [1:0]            first_chm_reg;
    logic [COUNT_BITS-1:0] frames_reg;
    logic [31:0]           bytes_reg;
    logic [7:0]            min_frames_reg;

    // result registers
    logic                  out_valid_reg;
    logic                  acc_reg;
    stop_t                 reason_reg;
    logic [FLEN_W-1:0]     flen_reg;
    logic                  enough_reg;

    // header fields
    logic [1:0] ver, lay, sri, chm;
    logic [3:0] bri;
    logic       pad;
    logic [2:0] kcol;
    logic [1:0] hcol;
    logic [3:0] bri_idx;
    logic [1:0] sri_idx;
    logic [8:0] kbps;
    logic [7:0] coef;

    assign ver = hdr_reg[20:19];
    assign lay = hdr_reg[18:17];
    assign bri = hdr_reg[15:12];
    assign sri = hdr_reg[11:10];
    assign pad = hdr_reg[9];
    assign chm = hdr_reg[7:6];

    always_comb
    begin
        if (ver == VER_MPEG1)
        begin
            kcol = {1'b0, 2'd3 - lay};
        end
        else
        begin
            kcol = (lay == LAY_1) ? 3'd3 : 3'd4;
        end
        hcol    = (ver == VER_MPEG1) ? 2'd0 : ((ver == VER_MPEG2) ? 2'd1 : 2'd2);
        bri_idx = (bri == BRI_BAD) ? BRI_FREE : bri;
        sri_idx = (sri == SRI_RESERVED) ? 2'd0 : sri;
        kbps    = KBPS_TAB[bri_idx][kcol];
        if (lay == LAY_1)
        begin
            coef = COEF_L1;
        end
        else if (lay == LAY_2 || ver == VER_MPEG1)
        begin
            coef = COEF_1152;
        end
        else
        begin
            coef = COEF_576;
        end

        if (!mode_reg && !run_active_reg)
        begin
            pre_reason_next = STOP_ENDED;
        end
        else if (hdr_reg[31:24] != SYNC_B0 ||
                 (hdr_reg[23:16] & SYNC_B1_MASK) != SYNC_B1_MASK)
        begin
            pre_reason_next = STOP_SYNC;
        end
        else if (ver == VER_RESERVED || lay == LAY_RESERVED)
        begin
            pre_reason_next = STOP_VERLAY;
        end
        else if (bri == BRI_FREE || bri == BRI_BAD)
        begin
            pre_reason_next = STOP_BITRATE;
        end
        else if (sri == SRI_RESERVED)
        begin
            pre_reason_next = STOP_RATE;
        end
        else
        begin
            pre_reason_next = STOP_OK;
        end
    end

    assign stat.pre_ok   = (pre_reason_next == STOP_OK);
    assign stat.div_last = (cnt_reg == CNT_W'(NUM_W - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    // restoring divide step
    logic [HZ_W:0] rem_shift;
    logic [HZ_W:0] rem_diff;
    logic          q_bit;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, hz_reg};
    assign q_bit     = (rem_shift >= {1'b0, hz_reg});

    // commit evaluation; mode 1 clears the run before the header is checked
    logic [COUNT_BITS-1:0] frames_eff;
    logic [31:0]           bytes_eff;
    logic [FLEN_W-1:0]     q12;
    logic [FLEN_W-1:0]     flen_calc;
    logic [FLEN_W-1:0]     flen_fin;
    stop_t                 reason_fin;
    logic                  mismatch;
    logic [32:0]           bytes_sum;
    logic [COUNT_BITS-1:0] frames_upd;
    logic [31:0]           bytes_upd;
    logic [31:0]           frames32;

    assign frames_eff = mode_reg ? '0 : frames_reg;
    assign bytes_eff  = mode_reg ? '0 : bytes_reg;
    assign q12        = num_reg[FLEN_W-1:0];

    always_comb
    begin
        if (lay == LAY_1)
        begin
            flen_calc = (q12 + FLEN_W'(pad)) << 2;
        end
        else
        begin
            flen_calc = q12 + FLEN_W'(pad);
        end
        mismatch = (ver != first_ver_reg) || (lay != first_lay_reg) ||
                   (hz_reg != first_rate_reg) || (chm != first_chm_reg);

        if (pre_reason_reg != STOP_OK)
        begin
            reason_fin = pre_reason_reg;
            flen_fin   = '0;
        end
        else
        begin
            flen_fin = flen_calc;
            if (31'(flen_calc) > left_reg)
            begin
                reason_fin = STOP_OVERRUN;
            end
            else if (frames_eff != '0 && !mode_reg && mismatch)
            begin
                reason_fin = STOP_CHANGED;
            end
            else
            begin
                reason_fin = STOP_OK;
            end
        end

        bytes_sum = {1'b0, bytes_eff} + 33'(flen_fin);
        if (reason_fin == STOP_OK)
        begin
            frames_upd = (frames_eff == {COUNT_BITS{1'b1}}) ? frames_eff : frames_eff + 1'b1;
            bytes_upd  = bytes_sum[32] ? 32'hFFFF_FFFF : bytes_sum[31:0];
        end
        else
        begin
            frames_upd = frames_eff;
            bytes_upd  = bytes_eff;
        end
        frames32 = 32'(frames_upd);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            hdr_reg  <= header_word;
            left_reg <= bytes_left;
        end
        if (cmd.decode)
        begin
            pre_reason_reg <= pre_reason_next;
            kbpsk_reg      <= KBPSK_W'(kbps) * KBPSK_W'(KBPS_SCALE);
            coef_reg       <= coef;
            hz_reg         <= HZ_TAB[sri_idx][hcol];
        end
        if (cmd.mul)
        begin
            num_reg <= NUM_W'(kbpsk_reg) * NUM_W'(coef_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff[HZ_W-1:0] : rem_shift[HZ_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            acc_reg    <= (reason_fin == STOP_OK);
            reason_reg <= reason_fin;
            flen_reg   <= flen_fin;
            enough_reg <= (frames32 >= 32'(min_frames_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            first_ver_reg  <= '0;
            first_lay_reg  <= '0;
            first_rate_reg <= '0;
            first_chm_reg  <= '0;
            frames_reg     <= '0;
            bytes_reg      <= '0;
            min_frames_reg <= MIN_FRAMES_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_frames_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                out_valid_reg  <= 1'b1;
                run_active_reg <= (reason_fin == STOP_OK);
                frames_reg     <= frames_upd;
                bytes_reg      <= bytes_upd;
                if (reason_fin == STOP_OK && frames_eff == '0)
                begin
                    first_ver_reg  <= ver;
                    first_lay_reg  <= lay;
                    first_rate_reg <= hz_reg;
                    first_chm_reg  <= chm;
                end
                else if (mode_reg)
                begin
                    first_ver_reg  <= '0;
                    first_lay_reg  <= '0;
                    first_rate_reg <= '0;
                    first_chm_reg  <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [31:0] frames_out32;
    assign frames_out32 = 32'(frames_reg);

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_reg;
    assign stop_reason    = reason_reg;
    assign frame_length   = flen_reg;
    assign frame_count    = (frames_out32 > 32'h0000_FFFF) ? 16'hFFFF : frames_out32[15:0];
    assign run_length     = bytes_reg;
    assign enough_frames  = enough_reg;
    assign version_code   = first_ver_reg;
    assign layer_code     = first_lay_reg;
    assign sample_rate_hz = first_rate_reg;
    assign channel_mode   = first_chm_reg;

endmodule

/* rtl/core/mpeg_audio_frame_chain_checker_unit.sv */
// MPEG audio frame chain checker.
// Input channel (in_valid/in_ready): one transaction carries mode, header_word and
// bytes_left. mode 1 starts a new run with this header, mode 0 extends the run.
// Output channel (out_valid/out_ready): one transaction per input transaction with
// accepted, stop_reason, frame_length, the run counters and the first frame fields.
// Configuration: min_frames is written by cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce this.
// Timing: a header that decodes passes the decode and multiply states and a
// 26-step restoring divide (one quotient bit per cycle) before the commit state.
// Headers rejected on sync, version, layer, bitrate, rate or an ended run skip
// the multiply and the divide.
// The divider sets the throughput. One item is in work at a time.
// Stall: the result sits in an output register; the next item is taken while it
// waits, but it is not committed until the old result is gone.
// Reset: the run is inactive, counters and first frame fields are zero, min_frames
// is 8, no result is pending.
`timescale 1ns / 1ps

module mpeg_audio_frame_chain_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] header_word,
    input  logic [30:0] bytes_left,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [2:0]  stop_reason,
    output logic [11:0] frame_length,
    output logic [15:0] frame_count,
    output logic [31:0] run_length,
    output logic        enough_frames,
    output logic [1:0]  version_code,
    output logic [1:0]  layer_code,
    output logic [15:0] sample_rate_hz,
    output logic [1:0]  channel_mode
);
    import mafcc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mafcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mafcc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mode           (mode),
        .header_word    (header_word),
        .bytes_left     (bytes_left),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .stop_reason    (stop_reason),
        .frame_length   (frame_length),
        .frame_count    (frame_count),
        .run_length     (run_length),
        .enough_frames  (enough_frames),
        .version_code   (version_code),
        .layer_code     (layer_code),
        .sample_rate_hz (sample_rate_hz),
        .channel_mode   (channel_mode)
    );

endmodule

/* rtl/core/mafcc_checker.sv */
`timescale 1ns / 1ps

module mafcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic [2:0]  stop_reason,
    input logic [11:0] frame_length,
    input logic [15:0] frame_count,
    input logic [31:0] run_length
);
    import mafcc_pkg::*;

    // one item at a time: no second input right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    a_acc_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (stop_reason == STOP_OK)))
        else $error("accepted flag disagrees with stop reason");

    a_undecoded_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (stop_reason == STOP_SYNC || stop_reason == STOP_VERLAY ||
                       stop_reason == STOP_BITRATE || stop_reason == STOP_RATE ||
                       stop_reason == STOP_ENDED)) |-> (frame_length == '0))
        else $error("frame length reported for undecoded header");

    a_acc_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |->
            (frame_count != '0 && run_length >= 32'(frame_length)))
        else $error("accepted frame not reflected in run counters");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(stop_reason) &&
                                       $stable(frame_length)))
        else $error("stalled result changed");

endmodule

bind mpeg_audio_frame_chain_checker_unit mafcc_checker u_mafcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .stop_reason  (stop_reason),
    .frame_length (frame_length),
    .frame_count  (frame_count),
    .run_length   (run_length)
);

/* verif/tb_mpeg_audio_frame_chain_checker_unit.sv */
`timescale 1ns / 1ps

module tb_mpeg_audio_frame_chain_checker_unit;
    import mafcc_pkg::*;

    localparam logic [1:0] VER_MPEG25   = 2'd0;
    localparam logic [1:0] LAY_3        = 2'd1;
    localparam int         ITEM_TARGET  = 900;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         STALL_LIMIT  = 2000;   // cycles without any transaction
    localparam int         LONG_HOLD    = 200;
    localparam logic [31:0] FRAME_CAP   = (COUNT_BITS >= 32) ? 32'hFFFF_FFFF
                                          : 32'((64'd1 << COUNT_BITS) - 1);

    // kbit/s by bitrate index; columns: MPEG1 L1, L2, L3, MPEG2/2.5 L1, L2/L3
    localparam int unsigned KBPS_BY_INDEX [15][5] = '{
        '{0,   0,   0,   0,   0},
        '{32,  32,  32,  32,  8},
        '{64,  48,  40,  48,  16},
        '{96,  56,  48,  56,  24},
        '{128, 64,  56,  64,  32},
        '{160, 80,  64,  80,  40},
        '{192, 96,  80,  96,  48},
        '{224, 112, 96,  112, 56},
        '{256, 128, 112, 128, 64},
        '{288, 160, 128, 144, 80},
        '{320, 192, 160, 160, 96},
        '{352, 224, 192, 176, 112},
        '{384, 256, 224, 192, 128},
        '{416, 320, 256, 224, 144},
        '{448, 384, 320, 256, 160}
    };

    // rows: rate index; columns: MPEG1, MPEG2, MPEG2.5
    localparam int unsigned HZ_BY_INDEX [3][3] = '{
        '{44100, 22050, 11025},
        '{48000, 24000, 12000},
        '{32000, 16000, 8000}
    };

    typedef struct {
        logic        accepted;
        stop_t       reason;
        logic [11:0] flen;
        logic [15:0] count;
        logic [31:0] bytes;
        logic        enough;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [15:0] hz;
        logic [1:0]  chm;
    } chain_status_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [31:0] header_word;
    logic [30:0] bytes_left;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic [2:0]  stop_reason;
    logic [11:0] frame_length;
    logic [15:0] frame_count;
    logic [31:0] run_length;
    logic        enough_frames;
    logic [1:0]  version_code;
    logic [1:0]  layer_code;
    logic [15:0] sample_rate_hz;
    logic [1:0]  channel_mode;

    // predicted chain state
    logic        chain_on       = 1'b0;
    logic [1:0]  lead_ver       = '0;
    logic [1:0]  lead_lay       = '0;
    logic [15:0] lead_hz        = '0;
    logic [1:0]  lead_chm       = '0;
    logic [31:0] chain_frames   = '0;
    logic [31:0] chain_bytes    = '0;
    logic [7:0]  min_frames_cfg = MIN_FRAMES_RST;

    chain_status_t expected_status[$];
    int  errors        = 0;
    int  items_sent    = 0;
    int  idle_cycles   = 0;
    int  hold_request  = 0;
    bit  no_gaps       = 1'b0;

    mpeg_audio_frame_chain_checker_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .header_word    (header_word),
        .bytes_left     (bytes_left),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .stop_reason    (stop_reason),
        .frame_length   (frame_length),
        .frame_count    (frame_count),
        .run_length     (run_length),
        .enough_frames  (enough_frames),
        .version_code   (version_code),
        .layer_code     (layer_code),
        .sample_rate_hz (sample_rate_hz),
        .channel_mode   (channel_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned rate_hz(input logic [31:0] hw);
        int unsigned col;
        col = (hw[20:19] == VER_MPEG1) ? 0 : (hw[20:19] == VER_MPEG2) ? 1 : 2;
        return HZ_BY_INDEX[hw[11:10]][col];
    endfunction

    // only for headers that pass every code check
    function automatic logic [11:0] frame_bytes(input logic [31:0] hw);
        logic [1:0]  ver;
        logic [1:0]  lay;
        int unsigned col;
        int unsigned kbps;
        int unsigned spf;
        int unsigned len;
        ver = hw[20:19];
        lay = hw[18:17];
        if (ver == VER_MPEG1)
            col = 3 - lay;
        else
            col = (lay == LAY_1) ? 3 : 4;
        kbps = KBPS_BY_INDEX[hw[15:12]][col];
        if (lay == LAY_1)
            spf = 384;
        else if (lay == LAY_2 || ver == VER_MPEG1)
            spf = 1152;
        else
            spf = 576;
        if (lay == LAY_1)
            len = ((spf / 32) * (1000 * kbps) / rate_hz(hw) + hw[9]) * 4;
        else
            len = (spf / 8) * (1000 * kbps) / rate_hz(hw) + hw[9];
        return len[11:0];
    endfunction

    function automatic chain_status_t predict_frame(input logic new_run,
                                                    input logic [31:0] hw,
                                                    input logic [30:0] left);
        chain_status_t r;
        logic [1:0]    ver;
        logic [1:0]    lay;
        logic [1:0]    chm;
        logic [15:0]   hz;
        ver = hw[20:19];
        lay = hw[18:17];
        chm = hw[7:6];
        r.accepted = 1'b0;
        r.reason   = STOP_OK;
        r.flen     = '0;
        if (new_run)
        begin
            chain_on     = 1'b1;
            lead_ver     = '0;
            lead_lay     = '0;
            lead_hz      = '0;
            lead_chm     = '0;
            chain_frames = '0;
            chain_bytes  = '0;
        end
        if (!chain_on)
            r.reason = STOP_ENDED;
        else if (hw[31:24] != SYNC_B0 || (hw[23:16] & SYNC_B1_MASK) != SYNC_B1_MASK)
            r.reason = STOP_SYNC;
        else if (ver == VER_RESERVED || lay == LAY_RESERVED)
            r.reason = STOP_VERLAY;
        else if (hw[15:12] == BRI_FREE || hw[15:12] == BRI_BAD)
            r.reason = STOP_BITRATE;
        else if (hw[11:10] == SRI_RESERVED)
            r.reason = STOP_RATE;
        else
        begin
            r.flen = frame_bytes(hw);
            hz = 16'(rate_hz(hw));
            if (31'(r.flen) > left)
                r.reason = STOP_OVERRUN;
            else if (chain_frames != 0 && (ver != lead_ver || lay != lead_lay ||
                                           hz != lead_hz || chm != lead_chm))
                r.reason = STOP_CHANGED;
            else
            begin
                if (chain_frames == 0)
                begin
                    lead_ver = ver;
                    lead_lay = lay;
                    lead_hz  = hz;
                    lead_chm = chm;
                end
                if (chain_frames < FRAME_CAP)
                    chain_frames = chain_frames + 1;
                if (chain_bytes > 32'hFFFF_FFFF - 32'(r.flen))
                    chain_bytes = 32'hFFFF_FFFF;
                else
                    chain_bytes = chain_bytes + 32'(r.flen);
                r.accepted = 1'b1;
            end
        end
        if (r.reason != STOP_OK)
            chain_on = 1'b0;
        r.count  = (chain_frames > 32'hFFFF) ? 16'hFFFF : chain_frames[15:0];
        r.bytes  = chain_bytes;
        r.enough = (chain_frames >= 32'(min_frames_cfg));
        r.ver    = lead_ver;
        r.lay    = lead_lay;
        r.hz     = lead_hz;
        r.chm    = lead_chm;
        return r;
    endfunction

    function automatic logic [31:0] build_header(input logic [1:0] ver, lay,
                                                 input logic [3:0] bri,
                                                 input logic [1:0] sri,
                                                 input logic pad,
                                                 input logic [1:0] chm);
        logic [31:0] fill;
        fill = $urandom;
        return {SYNC_B0, SYNC_B1_MASK[7:5], ver, lay, fill[16], bri, sri, pad, fill[8],
                chm, fill[5:0]};
    endfunction

    function automatic logic [1:0] pick_version();
        case ($urandom_range(0, 2))
            0:       return VER_MPEG1;
            1:       return VER_MPEG2;
            default: return VER_MPEG25;
        endcase
    endfunction

    // bytes_left for a decodable header; tight sizes hit the overrun boundary
    function automatic logic [30:0] room_for(input logic [31:0] hw, input bit tight_ok);
        logic [11:0] need;
        int          pick;
        need = frame_bytes(hw);
        pick = tight_ok ? $urandom_range(0, 19) : $urandom_range(3, 19);
        case (pick)
            0:       return 31'(need);
            1:       return 31'(need) - 31'd1;
            2:       return 31'($urandom);
            3:       return 31'h7FFF_FFFF - 31'($urandom_range(0, 1000));
            default: return 31'(need) + 31'($urandom_range(0, 5000));
        endcase
    endfunction

    task automatic send_header(input logic new_run, input logic [31:0] hw,
                               input logic [30:0] left);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= new_run;
        header_word <= hw;
        bytes_left  <= left;
        do @(posedge clk); while (!in_ready);
        expected_status.push_back(predict_frame(new_run, hw, left));
        items_sent++;
    endtask

    task automatic send_noise(input logic new_run);
        logic [31:0] hw;
        hw = $urandom;
        if ($urandom_range(0, 3) == 0)
            hw[31:21] = {SYNC_B0, SYNC_B1_MASK[7:5]};
        send_header(new_run, hw, 31'($urandom));
    endtask

    // one run of frames sharing version, layer, rate and channel mode;
    // a rough chain may hit overrun and may end with a breaking header
    task automatic send_chain(input int n, input bit rough);
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [1:0]  sri;
        logic [1:0]  chm;
        logic [1:0]  alt;
        logic [31:0] hw;
        logic [11:0] need;
        ver = pick_version();
        lay = 2'($urandom_range(1, 3));
        sri = 2'($urandom_range(0, 2));
        chm = 2'($urandom_range(0, 3));
        for (int i = 0; i < n; i++)
        begin
            hw = build_header(ver, lay, 4'($urandom_range(1, 14)), sri,
                              1'($urandom_range(0, 1)), chm);
            send_header(i == 0, hw, room_for(hw, rough));
        end
        if (rough)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    hw = build_header(ver, lay, 4'($urandom_range(1, 14)), sri,
                                      1'($urandom_range(0, 1)), chm);
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            do alt = pick_version(); while (alt == ver);
                            hw[20:19] = alt;
                        end
                        1: hw[18:17] = (lay == LAY_1) ? LAY_3 : lay + 2'd1;
                        2: hw[11:10] = (sri == 2'd2) ? 2'd0 : sri + 2'd1;
                        default: hw[7:6] = chm ^ 2'($urandom_range(1, 3));
                    endcase
                    send_header(1'b0, hw, room_for(hw, 1'b0));
                end
                1:
                begin
                    hw = build_header(ver, lay, 4'($urandom_range(1, 14)), sri,
                                      1'($urandom_range(0, 1)), chm);
                    need = frame_bytes(hw);
                    send_header(1'b0, hw, 31'($urandom_range(0, need - 1)));
                end
                2: send_noise(1'b0);
                3:
                begin
                    hw = build_header(ver, lay, 4'($urandom_range(1, 14)), sri,
                                      1'($urandom_range(0, 1)), chm);
                    case ($urandom_range(0, 3))
                        0:       hw[20:19] = VER_RESERVED;
                        1:       hw[18:17] = LAY_RESERVED;
                        2:       hw[15:12] = $urandom_range(0, 1) ? BRI_FREE : BRI_BAD;
                        default: hw[11:10] = SRI_RESERVED;
                    endcase
                    send_header(1'b0, hw, 31'($urandom));
                end
                default: ;
            endcase
            repeat ($urandom_range(0, 2)) send_noise(1'b0);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_min_frames(input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= value;
        min_frames_cfg  = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed_headers();
        logic [31:0] hw;
        // no run after reset
        send_header(1'b0, build_header(VER_MPEG1, LAY_3, 4'd9, 2'd0, 1'b0, 2'd2), 31'd1000);
        // sync and reserved codes
        send_header(1'b1, 32'h7FFB_9064, 31'd5000);
        send_header(1'b1, {SYNC_B0, 3'b110, 21'h1B9064}, 31'd5000);
        send_header(1'b1, 32'h0000_0000, 31'd0);
        send_header(1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_header(1'b1, build_header(VER_RESERVED, LAY_3, 4'd9, 2'd0, 1'b0, 2'd0), 31'd5000);
        send_header(1'b1, build_header(VER_MPEG1, LAY_RESERVED, 4'd9, 2'd0, 1'b0, 2'd0),
                    31'd5000);
        send_header(1'b1, build_header(VER_MPEG1, LAY_3, BRI_FREE, 2'd0, 1'b0, 2'd0),
                    31'd5000);
        send_header(1'b1, build_header(VER_MPEG1, LAY_3, BRI_BAD, 2'd0, 1'b0, 2'd0),
                    31'd5000);
        send_header(1'b1, build_header(VER_MPEG1, LAY_3, 4'd9, SRI_RESERVED, 1'b0, 2'd0),
                    31'd5000);
        // layer 1 with padding, exact fit, then a rate change ends the run
        hw = build_header(VER_MPEG1, LAY_1, 4'd14, 2'd2, 1'b1, 2'd1);
        send_header(1'b1, hw, 31'(frame_bytes(hw)));
        hw = build_header(VER_MPEG1, LAY_1, 4'd1, 2'd2, 1'b0, 2'd1);
        send_header(1'b0, hw, 31'(frame_bytes(hw)));
        send_header(1'b0, build_header(VER_MPEG1, LAY_1, 4'd1, 2'd0, 1'b0, 2'd1), 31'd9000);
        send_header(1'b0, build_header(VER_MPEG1, LAY_1, 4'd1, 2'd2, 1'b0, 2'd1), 31'd9000);
        // first frame one byte short, then largest bytes_left
        hw = build_header(VER_MPEG1, LAY_2, 4'd14, 2'd2, 1'b0, 2'd0);
        send_header(1'b1, hw, 31'(frame_bytes(hw)) - 31'd1);
        send_header(1'b1, hw, 31'h7FFF_FFFF);
        send_header(1'b0, build_header(VER_MPEG1, LAY_2, 4'd3, 2'd2, 1'b0, 2'd3), 31'd9000);
        hw = build_header(VER_MPEG1, LAY_3, 4'd14, 2'd1, 1'b1, 2'd0);
        send_header(1'b1, hw, 31'(frame_bytes(hw)));
        send_header(1'b0, build_header(VER_MPEG1, LAY_2, 4'd14, 2'd1, 1'b0, 2'd0), 31'd9000);
        send_header(1'b1, build_header(VER_MPEG2, LAY_1, 4'd14, 2'd2, 1'b1, 2'd2), 31'd9000);
        send_header(1'b0, build_header(VER_MPEG2, LAY_2, 4'd14, 2'd2, 1'b0, 2'd2), 31'd9000);
        send_header(1'b1, build_header(VER_MPEG2, LAY_3, 4'd14, 2'd2, 1'b1, 2'd3), 31'd9000);
        send_header(1'b0, build_header(VER_MPEG25, LAY_3, 4'd14, 2'd2, 1'b1, 2'd3),
                    31'd9000);
        send_header(1'b1, build_header(VER_MPEG25, LAY_1, 4'd14, 2'd2, 1'b1, 2'd0), 31'd0);
        send_header(1'b1, build_header(VER_MPEG25, LAY_2, 4'd1, 2'd0, 1'b0, 2'd1), 31'd9000);
        send_header(1'b1, build_header(VER_MPEG2, LAY_2, 4'd14, 2'd2, 1'b1, 2'd1), 31'd9000);
        drain_results();
    endtask

    task automatic test_min_frames_settings();
        set_min_frames(8'd0);
        send_chain(4, 1'b1);
        drain_results();
        set_min_frames(8'd1);
        send_chain(4, 1'b1);
        drain_results();
        // a clean run long enough to cross the largest threshold
        set_min_frames(8'd255);
        send_chain(260, 1'b0);
        send_noise(1'b0);
        drain_results();
        set_min_frames(8'($urandom_range(2, 254)));
        send_chain($urandom_range(4, 12), 1'b1);
        drain_results();
        set_min_frames(MIN_FRAMES_RST);
    endtask

    task automatic test_output_backpressure();
        no_gaps      = 1'b1;
        hold_request = LONG_HOLD;
        send_chain(12, 1'b0);
        no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic test_random_chains();
        int burst_end;
        burst_end = items_sent + 80;
        no_gaps   = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= burst_end)
                no_gaps = 1'b0;
            if ($urandom_range(0, 9) == 0)
                send_noise(1'($urandom_range(0, 1)));
            else
                send_chain($urandom_range(1, 12), 1'b1);
        end
        no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        chain_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result transaction with no header outstanding");
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("accepted", want.accepted, accepted);
                check_field("stop_reason", want.reason, stop_reason);
                check_field("frame_length", want.flen, frame_length);
                check_field("frame_count", want.count, frame_count);
                check_field("run_length", want.bytes, run_length);
                check_field("enough_frames", want.enough, enough_frames);
                check_field("version_code", want.ver, version_code);
                check_field("layer_code", want.lay, layer_code);
                check_field("sample_rate_hz", want.hz, sample_rate_hz);
                check_field("channel_mode", want.chm, channel_mode);
            end
        end
    end

    // result sink: per result a random stall, a requested hold or none (no_gaps), counted once the result is waiting
    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        out_ready <= 1'b1;
        forever
        begin
            do @(posedge clk); while (!(out_valid && out_ready));
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
            end
            else if (no_gaps)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        mode        = 1'b0;
        header_word = '0;
        bytes_left  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_headers();
        test_min_frames_settings();
        test_output_backpressure();
        test_random_chains();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
